// ===== hdl/ulr_pkg.sv =====
// ----------------------------------------------------------------------------
// ulr_pkg
// Shared types and constants for the uniform linear resampler.
// ----------------------------------------------------------------------------
package ulr_pkg;

   // Defaults for the top-level parameters
   localparam int MAX_BURST_DEF   = 64;
   localparam int COORD_WIDTH_DEF = 24;

   // Fixed field widths
   localparam int TIME_W   = 32;
   localparam int PERIOD_W = 20;
   localparam int FRAC_W   = 17;   // Q1.16 fraction, 0..65536
   localparam int NVAL     = 7;    // six signed coordinates, then shoulder width

   // Shared divider sizing
   localparam int DIV_DW = 49;     // dividend and quotient width
   localparam int DIV_SW = 32;     // divisor width

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_OUT_PERIOD = 1'b0;   // register index, paddr[2]
   localparam logic [PERIOD_W-1:0] OUT_PERIOD_RESET = PERIOD_W'(16667);

   localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(65536);

   // Divider status
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GAP_CHK,
      ST_GAP_DIV,
      ST_GAP_MUL,
      ST_GAP_UPD,
      ST_END_CHK,
      ST_END_DIV,
      ST_END_REM,
      ST_OUT_START,
      ST_FRAC_CHK,
      ST_FRAC_DIV,
      ST_MIX_ISSUE,
      ST_MIX_WAIT,
      ST_LOAD,
      ST_FINISH
   } state_type;

endpackage

// ===== hdl/ulr_if.sv =====
// ----------------------------------------------------------------------------
// ulr_if
// Valid/ready channels for samples in and resampled points out.
// ----------------------------------------------------------------------------
interface ulr_req_if #(parameter int CW = 24);
   logic                 valid;
   logic                 ready;
   logic [31:0]          sample_time;
   logic signed [CW-1:0] left_x;
   logic signed [CW-1:0] left_y;
   logic signed [CW-1:0] right_x;
   logic signed [CW-1:0] right_y;
   logic signed [CW-1:0] center_x;
   logic signed [CW-1:0] center_y;
   logic [CW-1:0]        shoulder_width;
   logic                 seq_end;

   modport source (output valid, sample_time, left_x, left_y, right_x, right_y,
                   center_x, center_y, shoulder_width, seq_end, input ready);
   modport sink   (input valid, sample_time, left_x, left_y, right_x, right_y,
                   center_x, center_y, shoulder_width, seq_end, output ready);
endinterface

interface ulr_rsp_if #(parameter int CW = 24);
   logic                 valid;
   logic                 ready;
   logic [31:0]          out_time;
   logic signed [CW-1:0] out_left_x;
   logic signed [CW-1:0] out_left_y;
   logic signed [CW-1:0] out_right_x;
   logic signed [CW-1:0] out_right_y;
   logic signed [CW-1:0] out_center_x;
   logic signed [CW-1:0] out_center_y;
   logic [CW-1:0]        out_shoulder;
   logic                 run_last;
   logic                 burst_overflow;

   modport source (output valid, out_time, out_left_x, out_left_y, out_right_x,
                   out_right_y, out_center_x, out_center_y, out_shoulder,
                   run_last, burst_overflow, input ready);
   modport sink   (input valid, out_time, out_left_x, out_left_y, out_right_x,
                   out_right_y, out_center_x, out_center_y, out_shoulder,
                   run_last, burst_overflow, output ready);
endinterface

// ===== hdl/ulr_divider.sv =====
// ----------------------------------------------------------------------------
// ulr_divider
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// ----------------------------------------------------------------------------
module ulr_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ulr_pkg::DIV_DW-1:0]    dividend,
   input  logic [ulr_pkg::DIV_SW-1:0]    divisor,
   output ulr_pkg::div_status_type       status,
   output logic [ulr_pkg::DIV_DW-1:0]    quotient
);
   import ulr_pkg::*;

   localparam int CNT_W = $clog2(DIV_DW);

   logic [DIV_DW-1:0] quo_ff, quo_in;
   logic [DIV_SW-1:0] rem_ff, rem_in;
   logic [DIV_SW-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [DIV_SW:0]   trial;
   logic [DIV_SW:0]   diff;
   logic              fits;

   // one restoring step
   assign trial = {rem_ff, quo_ff[DIV_DW-1]};
   assign fits  = trial >= {1'b0, dvs_ff};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DIV_SW-1:0] : trial[DIV_SW-1:0];
         quo_in = {quo_ff[DIV_DW-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIV_DW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

// ===== hdl/ulr_mix.sv =====
// ----------------------------------------------------------------------------
// ulr_mix
// Two-stage blend unit: a + round((b - a) * frac / 65536), halves rounded up.
// ----------------------------------------------------------------------------
module ulr_mix #(
   parameter int CW = ulr_pkg::COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [CW-1:0]                 a_raw,
   input  logic [CW-1:0]                 b_raw,
   input  logic [ulr_pkg::FRAC_W-1:0]    frac,
   input  logic                          is_signed,
   output logic                          done,
   output logic [CW-1:0]                 result
);
   import ulr_pkg::*;

   localparam int EW = CW + 2;           // extended operand width
   localparam int PW = EW + FRAC_W + 1;  // product width

   logic signed [EW-1:0] a_ext, b_ext, diff;
   logic signed [PW-1:0] prod;
   logic signed [PW-1:0] rounded;
   logic signed [PW-1:0] sum;

   logic signed [PW-1:0] prod_ff;
   logic signed [EW-1:0] a1_ff;
   logic                 v1_ff, v2_ff;
   logic [CW-1:0]        result_ff;

   // stage 1: extend, subtract, multiply
   assign a_ext = is_signed ? EW'($signed(a_raw)) : $signed(EW'(a_raw));
   assign b_ext = is_signed ? EW'($signed(b_raw)) : $signed(EW'(b_raw));
   assign diff  = b_ext - a_ext;
   assign prod  = PW'(diff) * $signed(PW'(frac));

   // stage 2: round and add back
   assign rounded = (prod_ff + $signed(PW'(32768))) >>> 16;
   assign sum     = PW'(a1_ff) + rounded;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= start;
         v2_ff <= v1_ff;
      end
      prod_ff   <= prod;
      a1_ff     <= a_ext;
      result_ff <= sum[CW-1:0];
   end

   assign done   = v2_ff;
   assign result = result_ff;

endmodule

// ===== hdl/uniform_linear_resampler_core.sv =====
// ----------------------------------------------------------------------------
// uniform_linear_resampler_core
// Resamples timestamped pose samples onto a uniform output time grid.
// ----------------------------------------------------------------------------
//  Channel     Dir  Handshake          Carries
//  req_chan    in   valid/ready        one timestamped pose sample
//  rsp_chan    out  valid/ready        one grid point, 0..MAX_BURST per request
//  psel..      in   APB, pready = 1    out_period at byte address 0
//
//  A request that starts a sequence is only stored. Otherwise the sequencer
//  does its setup with up to two divisions in the shared 49-step divider, then
//  per result an optional fraction divide and seven blends, one after another.
//  Reset is synchronous; no clearing pass. A stalled rsp_chan holds the
//  sequencer at the result load; a new request is taken while the last result
//  still waits in the output register.
// ----------------------------------------------------------------------------
module uniform_linear_resampler_core #(
   parameter int MAX_BURST   = ulr_pkg::MAX_BURST_DEF,
   parameter int COORD_WIDTH = ulr_pkg::COORD_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   ulr_req_if.sink                           req_chan,
   ulr_rsp_if.source                         rsp_chan,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [ulr_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [ulr_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [ulr_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);
   import ulr_pkg::*;

   localparam int CW = COORD_WIDTH;
   localparam int NW = $clog2(MAX_BURST + 1);

   state_type state_ff, state_in;

   logic [PERIOD_W-1:0] period_ff, period_in;
   logic [PERIOD_W-1:0] p_eff;

   // sequence state
   logic              have_prev_ff, have_prev_in;
   logic [TIME_W-1:0] prev_time_ff, prev_time_in;
   logic [CW-1:0]     prev_val_ff [NVAL];
   logic [CW-1:0]     prev_val_in [NVAL];
   logic [TIME_W-1:0] first_ff, first_in;
   logic [TIME_W:0]   next_ff, next_in;
   logic [TIME_W:0]   emitted_ff, emitted_in;

   // current request
   logic [TIME_W-1:0] tb_ff, tb_in;
   logic [CW-1:0]     cur_ff [NVAL];
   logic [CW-1:0]     cur_in [NVAL];
   logic              end_ff, end_in;

   // per-request work registers
   logic [TIME_W:0]   cnt_ff, cnt_in;
   logic [TIME_W+1:0] prod_ff, prod_in;
   logic [TIME_W:0]   gap_time_ff, gap_time_in;
   logic [NW-1:0]     gap_n_ff, gap_n_in;
   logic [NW-1:0]     held_n_ff, held_n_in;
   logic              ovf_ff, ovf_in;
   logic [TIME_W+1:0] total_ff, total_in;
   logic [NW-1:0]     k_ff, k_in;
   logic [TIME_W:0]   t_ff, t_in;
   logic [FRAC_W-1:0] frac_ff, frac_in;
   logic [2:0]        j_ff, j_in;
   logic [CW-1:0]     res_ff [NVAL];
   logic [CW-1:0]     res_in [NVAL];

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [TIME_W-1:0] rsp_time_ff, rsp_time_in;
   logic [CW-1:0]     rsp_val_ff [NVAL];
   logic [CW-1:0]     rsp_val_in [NVAL];
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_ovf_ff, rsp_ovf_in;

   // shared units
   logic                div_start;
   logic [DIV_DW-1:0]   div_dividend;
   logic [DIV_SW-1:0]   div_divisor;
   div_status_type      div_status;
   logic [DIV_DW-1:0]   div_quotient;

   logic                mix_start;
   logic [CW-1:0]       mix_a;
   logic                mix_done;
   logic [CW-1:0]       mix_result;

   logic              req_fire;
   logic [NW-1:0]     n_w;
   logic              held_now;
   logic [TIME_W-1:0] num_w, d_w;
   logic [TIME_W+1:0] rem_w;
   logic [TIME_W+1:0] room_w;
   logic              csr_write;

   // ---------------------------------------------------------------
   // configuration port
   assign csr_write = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == CSR_IDX_OUT_PERIOD) ?
                      CSR_DATA_W'(period_ff) : '0;
   assign p_eff     = (period_ff == '0) ? PERIOD_W'(1) : period_ff;

   always_comb begin
      period_in = period_ff;
      if (csr_write && (paddr[2] == CSR_IDX_OUT_PERIOD)) begin
         period_in = pwdata[PERIOD_W-1:0];
      end
   end

   // ---------------------------------------------------------------
   // handshake helpers
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && (state_ff == ST_IDLE);
   assign n_w            = gap_n_ff + held_n_ff;
   assign held_now       = (k_ff >= gap_n_ff);
   assign num_w          = t_ff[TIME_W-1:0] - prev_time_ff;
   assign d_w            = tb_ff - prev_time_ff;
   assign rem_w          = (total_ff > {1'b0, emitted_ff}) ?
                           total_ff - {1'b0, emitted_ff} : '0;
   assign room_w         = (TIME_W+2)'(MAX_BURST) - (TIME_W+2)'(gap_n_ff);
   assign mix_a          = held_now ? cur_ff[j_ff] : prev_val_ff[j_ff];

   // ---------------------------------------------------------------
   // sequencer
   always_comb begin
      state_in     = state_ff;
      have_prev_in = have_prev_ff;
      prev_time_in = prev_time_ff;
      prev_val_in  = prev_val_ff;
      first_in     = first_ff;
      next_in      = next_ff;
      emitted_in   = emitted_ff;
      tb_in        = tb_ff;
      cur_in       = cur_ff;
      end_in       = end_ff;
      cnt_in       = cnt_ff;
      prod_in      = prod_ff;
      gap_time_in  = gap_time_ff;
      gap_n_in     = gap_n_ff;
      held_n_in    = held_n_ff;
      ovf_in       = ovf_ff;
      total_in     = total_ff;
      k_in         = k_ff;
      t_in         = t_ff;
      frac_in      = frac_ff;
      j_in         = j_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_time_in  = rsp_time_ff;
      rsp_val_in   = rsp_val_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      mix_start    = 1'b0;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               tb_in     = req_chan.sample_time;
               cur_in[0] = req_chan.left_x;
               cur_in[1] = req_chan.left_y;
               cur_in[2] = req_chan.right_x;
               cur_in[3] = req_chan.right_y;
               cur_in[4] = req_chan.center_x;
               cur_in[5] = req_chan.center_y;
               cur_in[6] = req_chan.shoulder_width;
               end_in    = req_chan.seq_end;
               gap_n_in  = '0;
               held_n_in = '0;
               ovf_in    = 1'b0;
               if (have_prev_ff) begin
                  state_in = ST_GAP_CHK;
               end else if (!req_chan.seq_end) begin
                  // first sample of a sequence is only stored
                  have_prev_in   = 1'b1;
                  prev_time_in   = req_chan.sample_time;
                  prev_val_in[0] = req_chan.left_x;
                  prev_val_in[1] = req_chan.left_y;
                  prev_val_in[2] = req_chan.right_x;
                  prev_val_in[3] = req_chan.right_y;
                  prev_val_in[4] = req_chan.center_x;
                  prev_val_in[5] = req_chan.center_y;
                  prev_val_in[6] = req_chan.shoulder_width;
                  first_in       = req_chan.sample_time;
                  next_in        = {1'b0, req_chan.sample_time};
                  emitted_in     = '0;
               end
            end
         end

         // grid points inside the gap: count = (tb - next) / p + 1
         ST_GAP_CHK: begin
            if (next_ff <= {1'b0, tb_ff}) begin
               div_start    = 1'b1;
               div_dividend = DIV_DW'(tb_ff - next_ff[TIME_W-1:0]);
               div_divisor  = DIV_SW'(p_eff);
               state_in     = ST_GAP_DIV;
            end else begin
               state_in = ST_END_CHK;
            end
         end

         ST_GAP_DIV: begin
            if (div_status.done) begin
               cnt_in   = {1'b0, div_quotient[TIME_W-1:0]} + 1'b1;
               state_in = ST_GAP_MUL;
            end
         end

         ST_GAP_MUL: begin
            prod_in  = (TIME_W+2)'(cnt_ff * p_eff);
            state_in = ST_GAP_UPD;
         end

         ST_GAP_UPD: begin
            gap_time_in = next_ff;
            next_in     = next_ff + prod_ff[TIME_W:0];
            emitted_in  = emitted_ff + cnt_ff;
            if (cnt_ff > (TIME_W+1)'(MAX_BURST)) begin
               gap_n_in = NW'(MAX_BURST);
               ovf_in   = 1'b1;
            end else begin
               gap_n_in = cnt_ff[NW-1:0];
            end
            state_in = ST_END_CHK;
         end

         // sequence end: total = max(2, round((t1 - t0) / p) + 1)
         ST_END_CHK: begin
            if (!end_ff) begin
               state_in = ST_OUT_START;
            end else if (tb_ff > first_ff) begin
               div_start    = 1'b1;
               div_dividend = DIV_DW'({tb_ff - first_ff, 1'b0}) + DIV_DW'(p_eff);
               div_divisor  = DIV_SW'({p_eff, 1'b0});
               state_in     = ST_END_DIV;
            end else begin
               total_in = (TIME_W+2)'(2);
               state_in = ST_END_REM;
            end
         end

         ST_END_DIV: begin
            if (div_status.done) begin
               total_in = div_quotient[TIME_W+1:0] + 1'b1;
               if (div_quotient[TIME_W+1:0] == '0) begin
                  total_in = (TIME_W+2)'(2);
               end
               state_in = ST_END_REM;
            end
         end

         // held points fill what is left, up to the burst limit
         ST_END_REM: begin
            if (rem_w > room_w) begin
               held_n_in = room_w[NW-1:0];
               ovf_in    = 1'b1;
            end else begin
               held_n_in = rem_w[NW-1:0];
            end
            state_in = ST_OUT_START;
         end

         ST_OUT_START: begin
            k_in = '0;
            j_in = '0;
            t_in = (gap_n_ff != '0) ? gap_time_ff : next_ff;
            if (n_w == '0) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_FRAC_CHK;
            end
         end

         // fraction = (t - ta) / (tb - ta), clamped
         ST_FRAC_CHK: begin
            if (held_now || (tb_ff <= prev_time_ff) ||
                (t_ff[TIME_W-1:0] <= prev_time_ff)) begin
               frac_in  = '0;
               state_in = ST_MIX_ISSUE;
            end else if (num_w >= d_w) begin
               frac_in  = FRAC_ONE;
               state_in = ST_MIX_ISSUE;
            end else begin
               div_start    = 1'b1;
               div_dividend = {1'b0, num_w, 16'h0000} + DIV_DW'(d_w >> 1);
               div_divisor  = d_w;
               state_in     = ST_FRAC_DIV;
            end
         end

         ST_FRAC_DIV: begin
            if (div_status.done) begin
               frac_in  = div_quotient[FRAC_W-1:0];
               state_in = ST_MIX_ISSUE;
            end
         end

         ST_MIX_ISSUE: begin
            mix_start = 1'b1;
            state_in  = ST_MIX_WAIT;
         end

         ST_MIX_WAIT: begin
            if (mix_done) begin
               res_in[j_ff] = mix_result;
               if (j_ff == 3'(NVAL - 1)) begin
                  j_in     = '0;
                  state_in = ST_LOAD;
               end else begin
                  j_in     = j_ff + 1'b1;
                  state_in = ST_MIX_ISSUE;
               end
            end
         end

         // hand the point to the output register
         ST_LOAD: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_time_in  = t_ff[TIME_W-1:0];
               rsp_val_in   = res_ff;
               rsp_last_in  = (k_ff == n_w - 1'b1);
               rsp_ovf_in   = ovf_ff;
               if (k_ff == n_w - 1'b1) begin
                  state_in = ST_FINISH;
               end else begin
                  k_in     = k_ff + 1'b1;
                  t_in     = (k_ff + 1'b1 == gap_n_ff) ? next_ff :
                             t_ff + (TIME_W+1)'(p_eff);
                  state_in = ST_FRAC_CHK;
               end
            end
         end

         ST_FINISH: begin
            if (end_ff) begin
               have_prev_in = 1'b0;
               prev_time_in = '0;
               for (int i = 0; i < NVAL; i++) begin
                  prev_val_in[i] = '0;
               end
               first_in   = '0;
               next_in    = '0;
               emitted_in = '0;
            end else begin
               prev_time_in = tb_ff;
               prev_val_in  = cur_ff;
            end
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------
   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         period_ff    <= OUT_PERIOD_RESET;
         have_prev_ff <= 1'b0;
         prev_time_ff <= '0;
         first_ff     <= '0;
         next_ff      <= '0;
         emitted_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         gap_n_ff     <= '0;
         held_n_ff    <= '0;
         for (int i = 0; i < NVAL; i++) begin
            prev_val_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         period_ff    <= period_in;
         have_prev_ff <= have_prev_in;
         prev_time_ff <= prev_time_in;
         first_ff     <= first_in;
         next_ff      <= next_in;
         emitted_ff   <= emitted_in;
         rsp_valid_ff <= rsp_valid_in;
         gap_n_ff     <= gap_n_in;
         held_n_ff    <= held_n_in;
         prev_val_ff  <= prev_val_in;
      end
      tb_ff       <= tb_in;
      cur_ff      <= cur_in;
      end_ff      <= end_in;
      cnt_ff      <= cnt_in;
      prod_ff     <= prod_in;
      gap_time_ff <= gap_time_in;
      ovf_ff      <= ovf_in;
      total_ff    <= total_in;
      k_ff        <= k_in;
      t_ff        <= t_in;
      frac_ff     <= frac_in;
      j_ff        <= j_in;
      res_ff      <= res_in;
      rsp_time_ff <= rsp_time_in;
      rsp_val_ff  <= rsp_val_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   // ---------------------------------------------------------------
   // shared units
   ulr_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .status   (div_status),
      .quotient (div_quotient)
   );

   ulr_mix #(.CW(CW)) u_mix (
      .clock     (clock),
      .reset     (reset),
      .start     (mix_start),
      .a_raw     (mix_a),
      .b_raw     (cur_ff[j_ff]),
      .frac      (frac_ff),
      .is_signed (j_ff != 3'(NVAL - 1)),
      .done      (mix_done),
      .result    (mix_result)
   );

   // ---------------------------------------------------------------
   // result channel
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.out_time       = rsp_time_ff;
   assign rsp_chan.out_left_x     = rsp_val_ff[0];
   assign rsp_chan.out_left_y     = rsp_val_ff[1];
   assign rsp_chan.out_right_x    = rsp_val_ff[2];
   assign rsp_chan.out_right_y    = rsp_val_ff[3];
   assign rsp_chan.out_center_x   = rsp_val_ff[4];
   assign rsp_chan.out_center_y   = rsp_val_ff[5];
   assign rsp_chan.out_shoulder   = rsp_val_ff[6];
   assign rsp_chan.run_last       = rsp_last_ff;
   assign rsp_chan.burst_overflow = rsp_ovf_ff;

   // ---------------------------------------------------------------
   // assertions
   a_idle_div_quiet : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !div_status.busy)
      else $error("divider busy while sequencer idle");

   a_load_in_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |-> (k_ff < n_w))
      else $error("result index past request total");

   a_burst_limit : assert property (@(posedge clock) disable iff (reset)
      ({1'b0, gap_n_ff} + {1'b0, held_n_ff}) <= (NW+1)'(MAX_BURST))
      else $error("burst count above limit");

   a_first_stored : assert property (@(posedge clock) disable iff (reset)
      (req_fire && !have_prev_ff && !req_chan.seq_end) |=> have_prev_ff)
      else $error("sequence start not stored");

endmodule
